/* hdl/moc_pkg.sv */
`default_nettype none

package moc_pkg;

  // fixed field widths
  localparam int ELEM_VALUE_W = 16;
  localparam int DIM_W        = 5;
  localparam int SCALE_W      = 35;

  // parameter defaults
  localparam int MAX_DIM_DEF    = 16;
  localparam int ELEM_WIDTH_DEF = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd4;

  typedef struct packed {
    logic signed [ELEM_VALUE_W-1:0] elem_value;
    logic                           last_elem;
  } moc_in_t;

  typedef struct packed {
    logic               is_orthogonal;
    logic [SCALE_W-1:0] scale;
  } moc_out_t;

  // control that travels with one product term down the mac pipeline
  typedef struct packed {
    logic valid;
    logic zero_a;
    logic zero_b;
    logic first_k;
    logic last_k;
    logic first_dot;
    logic diag;
    logic last_dot;
  } moc_tag_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT,
    ST_PEND
  } moc_state_e;

endpackage

`default_nettype wire

/* hdl/moc_mac.sv */
`default_nettype none

module moc_mac #(
  parameter int MAX_DIM    = moc_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = moc_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire moc_pkg::moc_tag_t           tag_i,
  input  wire logic [ELEM_WIDTH-1:0]       op_a_i,
  input  wire logic [ELEM_WIDTH-1:0]       op_b_i,
  output logic                             done_o,
  output logic                             ok_o,
  output logic [moc_pkg::SCALE_W-1:0]      scale_o
);
  import moc_pkg::*;

  localparam int ProdW = 2 * ELEM_WIDTH;
  localparam int SumW  = ProdW + $clog2(MAX_DIM);
  localparam int AccW  = (SumW > 64) ? 64 : SumW;
  localparam int ExtW  = (AccW > SCALE_W) ? AccW : SCALE_W;

  logic signed [ELEM_WIDTH-1:0] a_gated, b_gated;
  logic signed [ProdW-1:0]      prod_q;
  logic signed [AccW-1:0]       acc_q, acc_d, dot_q, c00_q;
  logic signed [ExtW-1:0]       c00_ext;
  moc_tag_t                     tag2_q, tag3_q, tag3_d;
  logic                         ok_q, done_q;

  // positions not received in this matrix read as zero
  assign a_gated = tag_i.zero_a ? '0 : signed'(op_a_i);
  assign b_gated = tag_i.zero_b ? '0 : signed'(op_b_i);

  assign acc_d = (tag2_q.first_k ? '0 : acc_q) + AccW'(prod_q);

  // only a finished dot product moves on to the compare stage
  always_comb begin
    tag3_d       = tag2_q;
    tag3_d.valid = tag2_q.valid && tag2_q.last_k;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_gated * b_gated;
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag2_q.valid && tag2_q.last_k) begin
      dot_q <= acc_d;
    end
    if (tag3_q.valid && tag3_q.first_dot) begin
      c00_q <= dot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      tag3_q <= '0;
      ok_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      tag2_q <= tag_i;
      tag3_q <= tag3_d;
      done_q <= tag3_q.valid && tag3_q.last_dot;
      if (tag3_q.valid) begin
        if (tag3_q.first_dot) begin
          ok_q <= (dot_q != '0);
        end else if (tag3_q.diag) begin
          ok_q <= ok_q && (dot_q == c00_q);
        end else begin
          ok_q <= ok_q && (dot_q == '0);
        end
      end
    end
  end

  assign c00_ext = ExtW'(c00_q);
  assign scale_o = c00_ext[SCALE_W-1:0];
  assign ok_o    = ok_q;
  assign done_o  = done_q;

  a_ok_needs_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_q |-> (c00_q != '0))
    else $error("ok flag set with zero scale");

  a_terms_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag2_q.valid && !tag2_q.first_k) |-> $past(tag2_q.valid))
    else $error("gap inside a dot product");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!tag3_q.valid && !tag2_q.valid))
    else $error("terms still in flight at done");

endmodule

`default_nettype wire

/* hdl/matrix_orthogonality_check_unit.sv */
`default_nettype none

// channel  dir  handshake                width  word
// cfg      in   cfg_valid_i/cfg_ready_o  5      dim register
// in       in   in_valid_i/in_ready_o    17     one matrix element, row-major
// out      out  out_valid_o/out_ready_i  36     orthogonal flag and scale
//
// elements are taken while loading; the last one starts the check: dim^3 product
// terms are issued on the one shared multiply-accumulate and pass the memory read,
// product, accumulate and compare registers and a handoff state to the output word;
// only then is another element taken. reset sets dim to 4, the load count to 0; the
// element memory is not cleared, positions at or beyond the load count read as zero
// the handoff stalls while the previous result word still waits in the output register

module matrix_orthogonality_check_unit #(
  parameter int MAX_DIM    = moc_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = moc_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [moc_pkg::DIM_W-1:0] cfg_dim_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire moc_pkg::moc_in_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output moc_pkg::moc_out_t              out_data_o
);
  import moc_pkg::*;

  localparam int Depth   = MAX_DIM * MAX_DIM;
  localparam int AddrW   = $clog2(Depth);
  localparam int CntW    = AddrW + 1;
  localparam int IdxW    = $clog2(MAX_DIM);
  localparam int DimEffW = $clog2(MAX_DIM + 1);
  localparam int CmpW    = (DimEffW > DIM_W) ? DimEffW : DIM_W;

  moc_state_e state_q, state_d;

  logic [DIM_W-1:0]   dim_q;
  logic [CmpW-1:0]    dim_wide;
  logic [DimEffW-1:0] dim_eff;
  logic [IdxW-1:0]    dim_m1;
  logic [AddrW-1:0]   dim_step;

  logic [CntW-1:0]  count_q, count_d;
  logic             in_fire, wr_en, issue_en, out_load;
  logic [AddrW-1:0] wr_addr;

  logic [IdxW-1:0]  i_q, j_q, k_q;
  logic [AddrW-1:0] base_i_q, base_j_q;
  logic [AddrW-1:0] addr_a, addr_b;
  logic             k_last, j_last, i_last;

  logic [ELEM_WIDTH-1:0] mem [Depth];
  logic [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;
  moc_tag_t              tag_d, tag1_q;

  logic                  mac_done, mac_ok;
  logic [SCALE_W-1:0]    mac_scale;

  logic     out_valid_q;
  moc_out_t out_data_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      dim_q <= cfg_dim_i;
    end
  end

  // zero means one, above the store size means the store size
  assign dim_wide = CmpW'(dim_q);
  always_comb begin
    if (dim_q == '0) begin
      dim_eff = DimEffW'(1);
    end else if (dim_wide > CmpW'(MAX_DIM)) begin
      dim_eff = DimEffW'(MAX_DIM);
    end else begin
      dim_eff = DimEffW'(dim_wide);
    end
  end
  assign dim_m1   = IdxW'(dim_eff - DimEffW'(1));
  assign dim_step = AddrW'(dim_eff);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire && in_data_i.last_elem) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (i_last && j_last && k_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = ST_PEND;
        end
      end
      ST_PEND: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    issue_en   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_LOAD:  in_ready_o = 1'b1;
      ST_ISSUE: issue_en   = 1'b1;
      ST_WAIT:  ;
      ST_PEND:  out_load   = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // element load
  assign in_fire = in_valid_i && in_ready_o;
  assign wr_en   = in_fire && (count_q < CntW'(Depth));
  assign wr_addr = count_q[AddrW-1:0];

  always_comb begin
    count_d = count_q;
    if (out_load) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // row/column/term walk, row bases kept as running sums of dim
  assign k_last = (k_q == dim_m1);
  assign j_last = (j_q == dim_m1);
  assign i_last = (i_q == dim_m1);
  assign addr_a = base_i_q + AddrW'(k_q);
  assign addr_b = base_j_q + AddrW'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      base_i_q <= '0;
      base_j_q <= '0;
    end else if (!issue_en) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      base_i_q <= '0;
      base_j_q <= '0;
    end else if (!k_last) begin
      k_q <= k_q + IdxW'(1);
    end else begin
      k_q <= '0;
      if (!j_last) begin
        j_q      <= j_q + IdxW'(1);
        base_j_q <= base_j_q + dim_step;
      end else begin
        j_q      <= '0;
        base_j_q <= '0;
        if (!i_last) begin
          i_q      <= i_q + IdxW'(1);
          base_i_q <= base_i_q + dim_step;
        end
      end
    end
  end

  always_comb begin
    tag_d.valid     = issue_en;
    tag_d.zero_a    = {1'b0, addr_a} >= count_q;
    tag_d.zero_b    = {1'b0, addr_b} >= count_q;
    tag_d.first_k   = (k_q == '0);
    tag_d.last_k    = k_last;
    tag_d.first_dot = (i_q == '0) && (j_q == '0);
    tag_d.diag      = (i_q == j_q);
    tag_d.last_dot  = i_last && j_last;
  end

  // element memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= ELEM_WIDTH'($unsigned(in_data_i.elem_value));
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else begin
      tag1_q <= tag_d;
    end
  end

  moc_mac #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag1_q),
    .op_a_i  (rd_a_q),
    .op_b_i  (rd_b_q),
    .done_o  (mac_done),
    .ok_o    (mac_ok),
    .scale_o (mac_scale)
  );

  // output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.is_orthogonal <= mac_ok;
      out_data_q.scale         <= mac_scale;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_WAIT))
    else $error("mac finished outside wait state");

  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PEND))
    else $error("output word loaded outside pend state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("load count beyond store depth");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_LOAD) && $past(state_q == ST_PEND)) |-> (count_q == '0))
    else $error("load count not cleared after result");

endmodule

`default_nettype wire
